// ----- rtl/core/sdf_pkg.sv -----
// Shared types and constants for the stream duplicate filter.
`default_nettype none

package sdf_pkg;

   localparam int unsigned SEEN_ENTRIES_DEF = 256;
   localparam int unsigned VALUE_BITS_DEF   = 32;
   localparam int unsigned DATA_W           = 32;
   // list tag stored with every table entry; tag zero marks an empty slot
   localparam int unsigned EPOCH_BITS       = 8;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     end_of_list;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_out;
      logic                     is_duplicate;
      logic                     store_overflow;
      logic                     last_out;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic load_item;
      logic mem_read;
      logic insert;
      logic advance;
      logic record;
      logic rec_dup;
      logic rec_ovf;
      logic emit;
      logic end_list;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hit;
      logic vacant;
      logic full;
      logic probe_last;
      logic last_item;
      logic rsp_free;
      logic epoch_at_max;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/sdf_stream_if.sv -----
// Valid/ready stream channel carrying one payload item.
`default_nettype none

interface sdf_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sdf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/sdf_ctrl.sv -----
// Sequencer: clear sweep, hashed probe loop, insert and result hand-off.
`default_nettype none

module sdf_ctrl
   import sdf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   output      cmd_type    cmd,
   input  wire status_type status
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.hit) begin
               cmd.record  = 1'b1;
               cmd.rec_dup = 1'b1;
               state_in    = ST_EMIT;
            end else if (status.vacant && !status.full) begin
               cmd.insert = 1'b1;
               cmd.record = 1'b1;
               state_in   = ST_EMIT;
            end else if (status.vacant || status.probe_last) begin
               // whole table probed without a match or a free slot
               cmd.record  = 1'b1;
               cmd.rec_ovf = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
               if (status.last_item) begin
                  cmd.end_list = 1'b1;
                  if (status.epoch_at_max) begin
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/sdf_dpath.sv -----
// Datapath: key hashing, probe index, tagged seen table, fill count, output register.
`default_nettype none

module sdf_dpath
   import sdf_pkg::*;
#(
   parameter int unsigned SEEN_ENTRIES = SEEN_ENTRIES_DEF,
   parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cmd_type         cmd,
   output      status_type      status,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      rsp_payload_type rsp_payload
);

   localparam int unsigned IDX_BITS = $clog2(SEEN_ENTRIES);
   localparam int unsigned CNT_BITS = $clog2(SEEN_ENTRIES + 1);
   localparam int unsigned MEM_W    = EPOCH_BITS + VALUE_BITS;
   localparam int unsigned FOLDS    = (VALUE_BITS + IDX_BITS - 1) / IDX_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(SEEN_ENTRIES - 1);
   localparam logic [IDX_BITS:0]   ENTRIES_X = (IDX_BITS + 1)'(SEEN_ENTRIES);
   localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(SEEN_ENTRIES);

   logic [VALUE_BITS-1:0]     key_ff,    key_in;
   logic signed [DATA_W-1:0]  raw_ff,    raw_in;
   logic                      last_ff,   last_in;
   logic [IDX_BITS-1:0]       idx_ff,    idx_in;
   logic [IDX_BITS-1:0]       probes_ff, probes_in;
   logic [CNT_BITS-1:0]       count_ff,  count_in;
   logic [EPOCH_BITS-1:0]     epoch_ff,  epoch_in;
   logic [IDX_BITS-1:0]       clr_ff,    clr_in;
   logic                      dup_ff,    dup_in;
   logic                      ovf_ff,    ovf_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_ff,    rsp_in;

   logic [VALUE_BITS-1:0]        new_key;
   logic [FOLDS*IDX_BITS-1:0]    key_ext;
   logic [IDX_BITS-1:0]          fold;
   logic [IDX_BITS:0]            fold_x;
   logic [IDX_BITS-1:0]          home_idx;

   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_waddr;
   logic [MEM_W-1:0]      mem_wdata;
   logic [MEM_W-1:0]      mem_rdata;
   logic [EPOCH_BITS-1:0] rd_epoch;
   logic [VALUE_BITS-1:0] rd_key;

   // home slot: xor-fold of the key, brought below the table size
   always_comb begin
      new_key = VALUE_BITS'($unsigned(req_payload.value));
      key_ext = (FOLDS * IDX_BITS)'(new_key);
      fold    = '0;
      for (int i = 0; i < FOLDS; i++) begin
         fold = fold ^ key_ext[i*IDX_BITS +: IDX_BITS];
      end
      fold_x   = {1'b0, fold};
      home_idx = (fold_x >= ENTRIES_X) ? IDX_BITS'(fold_x - ENTRIES_X) : fold;
   end

   assign mem_we    = cmd.clear_wr | cmd.insert;
   assign mem_waddr = cmd.clear_wr ? clr_ff : idx_ff;
   assign mem_wdata = cmd.clear_wr ? '0 : {epoch_ff, key_ff};

   sdf_ram #(
      .WIDTH (MEM_W),
      .DEPTH (SEEN_ENTRIES)
   ) u_seen_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (cmd.mem_read),
      .raddr (idx_ff),
      .rdata (mem_rdata)
   );

   assign rd_epoch = mem_rdata[MEM_W-1 -: EPOCH_BITS];
   assign rd_key   = mem_rdata[VALUE_BITS-1:0];

   // an entry tagged with another list's epoch counts as empty
   always_comb begin
      status.vacant       = (rd_epoch != epoch_ff);
      status.hit          = (rd_epoch == epoch_ff) && (rd_key == key_ff);
      status.full         = (count_ff == FULL_CNT);
      status.probe_last   = (probes_ff == LAST_IDX);
      status.clear_last   = (clr_ff == LAST_IDX);
      status.last_item    = last_ff;
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
      status.epoch_at_max = &epoch_ff;
   end

   always_comb begin
      key_in       = key_ff;
      raw_in       = raw_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      probes_in    = probes_ff;
      count_in     = count_ff;
      epoch_in     = epoch_ff;
      clr_in       = clr_ff;
      dup_in       = dup_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.load_item) begin
         key_in    = new_key;
         raw_in    = req_payload.value;
         last_in   = req_payload.end_of_list;
         idx_in    = home_idx;
         probes_in = '0;
      end
      if (cmd.advance) begin
         idx_in    = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         probes_in = probes_ff + 1'b1;
      end
      if (cmd.clear_wr) begin
         clr_in = (clr_ff == LAST_IDX) ? '0 : clr_ff + 1'b1;
      end
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.end_list) begin
         count_in = '0;
         // epoch runs 1..max; wrap goes through a clear sweep
         epoch_in = (&epoch_ff) ? EPOCH_BITS'(1) : epoch_ff + 1'b1;
      end
      if (cmd.record) begin
         dup_in = cmd.rec_dup;
         ovf_in = cmd.rec_ovf;
      end
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.value_out      = raw_ff;
         rsp_in.is_duplicate   = dup_ff;
         rsp_in.store_overflow = ovf_ff;
         rsp_in.last_out       = last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         epoch_ff     <= EPOCH_BITS'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      raw_ff    <= raw_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      probes_ff <= probes_in;
      dup_ff    <= dup_in;
      ovf_ff    <= ovf_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/stream_duplicate_filter.sv -----
// Top level of the stream duplicate filter: per-list first-occurrence marking.
//
//   channel   dir   handshake             payload
//   req_ch    in    valid/ready (sink)    value, end_of_list
//   rsp_ch    out   valid/ready (source)  value_out, is_duplicate, store_overflow, last_out
//
// An item passes through accept, table read, compare and result load when its home
// slot answers, plus a further table read and compare for each further probe of the
// linear-probing hash table, whose single read port sets the rate. A value not found
// in a full table probes all SEEN_ENTRIES slots. After reset, and after every 255th
// list when the list tag wraps, a clear sweep writes all SEEN_ENTRIES slots with
// req_ch.ready low. The result register lets the next item be accepted while a result
// waits; a stalled rsp_ch holds the block in its result-load step.
`default_nettype none

module stream_duplicate_filter
   import sdf_pkg::*;
#(
   parameter int unsigned SEEN_ENTRIES = SEEN_ENTRIES_DEF,
   parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   sdf_stream_if.sink   req_ch,
   sdf_stream_if.source rsp_ch
);

   cmd_type         cmd;
   status_type      status;
   logic            req_ready;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;

   sdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sdf_dpath #(
      .SEEN_ENTRIES (SEEN_ENTRIES),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_ch.payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_payload)
   );

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_payload;

endmodule

`default_nettype wire

// ----- rtl/core/sdf_chk.sv -----
// Port-level checks for the stream duplicate filter, bound to the top level.
`default_nettype none

module sdf_chk
   import sdf_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_payload
);

   // reset starts the clear sweep with nothing pending on either side
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_ready))
      else $error("item pending or input open right after reset");

   // one item at a time: input closes after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in work");

   // a duplicate is never also an overflow
   a_dup_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.is_duplicate && rsp_payload.store_overflow))
      else $error("item marked both duplicate and overflow");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result dropped or changed");

endmodule

bind stream_duplicate_filter sdf_chk u_sdf_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

`default_nettype wire

// ----- verif/stream_duplicate_filter_tb.sv -----
// Self-checking testbench for stream_duplicate_filter: per-list duplicate marking.
`default_nettype none

module stream_duplicate_filter_tb
   import sdf_pkg::*;
();

   localparam int unsigned SEEN_ENTRIES   = 256;
   localparam int unsigned VALUE_BITS     = 32;
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned TAIL_CYCLES    = 600;
   localparam int unsigned RSP_HOLD_LEN   = 2000;

   logic clock;
   logic reset;

   sdf_stream_if #(.payload_type(req_payload_type)) req_if ();
   sdf_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   stream_duplicate_filter #(
      .SEEN_ENTRIES(SEEN_ENTRIES),
      .VALUE_BITS  (VALUE_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   // predictor state: values seen in the current list, in insert order
   logic [VALUE_BITS-1:0] seen_keys [SEEN_ENTRIES];
   int unsigned           seen_fill;

   rsp_payload_type expected_rsp [$];
   int unsigned     fail_count;
   int unsigned     quiet_cycles;
   bit              idle_enable;
   int unsigned     rsp_hold_len;
   int unsigned     rsp_gap_left;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic rsp_payload_type predict_filter(input req_payload_type item);
      logic [VALUE_BITS-1:0] key;
      bit                    hit;
      rsp_payload_type       rsp;
      key = item.value[VALUE_BITS-1:0];
      hit = 1'b0;
      for (int unsigned i = 0; i < seen_fill; i++) begin
         if (seen_keys[i] == key) hit = 1'b1;
      end
      rsp.value_out      = item.value;
      rsp.is_duplicate   = hit;
      rsp.store_overflow = 1'b0;
      rsp.last_out       = item.end_of_list;
      if (!hit) begin
         if (seen_fill < SEEN_ENTRIES) begin
            seen_keys[seen_fill] = key;
            seen_fill++;
         end else begin
            rsp.store_overflow = 1'b1;
         end
      end
      if (item.end_of_list) seen_fill = 0;
      return rsp;
   endfunction

   // valid stays high between back-to-back items; it only drops for a gap
   task automatic send_item(input logic signed [DATA_W-1:0] value, input logic eol);
      int unsigned     gap;
      req_payload_type item;
      item.value       = value;
      item.end_of_list = eol;
      gap = idle_enable ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      expected_rsp.push_back(predict_filter(item));
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_gap_left = 0;
      rsp_hold_len = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            rsp_hold_len--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (idle_enable && $urandom_range(0, 5) == 0) rsp_gap_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected item: value_out %0d", rsp_if.payload.value_out);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_if.payload.value_out !== want.value_out) begin
               $error("value_out: expected %0d, got %0d", want.value_out,
                      rsp_if.payload.value_out);
               fail_count++;
            end
            if (rsp_if.payload.is_duplicate !== want.is_duplicate) begin
               $error("is_duplicate: expected %0b, got %0b", want.is_duplicate,
                      rsp_if.payload.is_duplicate);
               fail_count++;
            end
            if (rsp_if.payload.store_overflow !== want.store_overflow) begin
               $error("store_overflow: expected %0b, got %0b", want.store_overflow,
                      rsp_if.payload.store_overflow);
               fail_count++;
            end
            if (rsp_if.payload.last_out !== want.last_out) begin
               $error("last_out: expected %0b, got %0b", want.last_out,
                      rsp_if.payload.last_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("stream_duplicate_filter_tb failed");
            $finish;
         end
      end
   end

   task automatic test_directed();
      idle_enable = 1'b1;
      send_item(32'sd0, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'h5555_5555, 1'b0);
      send_item(32'hAAAA_AAAA, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b1);
      // single-element lists and a short list: the store must be empty again after each
      send_item(32'sd5, 1'b1);
      send_item(32'sd5, 1'b1);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b0);
      send_item(-32'sd1, 1'b1);
      send_item(32'sd0, 1'b1);
   endtask

   task automatic test_store_full();
      bit                       taken [logic [31:0]];
      logic [31:0]              v;
      logic signed [DATA_W-1:0] stored_v;
      logic signed [DATA_W-1:0] spill_v;
      idle_enable = 1'b0;
      for (int i = 0; i < SEEN_ENTRIES; i++) begin
         do v = $urandom(); while (taken.exists(v));
         taken[v] = 1'b1;
         if (i == 17) stored_v = v;
         send_item(v, 1'b0);
      end
      idle_enable = 1'b1;
      do v = $urandom(); while (taken.exists(v));
      spill_v = v;
      // not remembered when full, so the repeat is unique again
      send_item(spill_v, 1'b0);
      send_item(spill_v, 1'b0);
      send_item(stored_v, 1'b0);
      send_item(~spill_v, 1'b0);
      send_item(stored_v, 1'b1);
      send_item(spill_v, 1'b0);
      send_item(stored_v, 1'b0);
      send_item(spill_v, 1'b1);
   endtask

   task automatic test_random_lists(input int unsigned item_goal);
      logic signed [DATA_W-1:0] pool [8];
      int unsigned              sent;
      int unsigned              list_len;
      int unsigned              list_no;
      int unsigned              r;
      logic signed [DATA_W-1:0] v;
      sent    = 0;
      list_no = 0;
      while (sent < item_goal) begin
         if (list_no % 16 == 0) idle_enable = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 3);
            case (r)
               0: pool[i] = $urandom_range(0, 15);
               1: pool[i] = -$signed(DATA_W'($urandom_range(1, 16)));
               default: pool[i] = $urandom();
            endcase
         end
         list_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
         for (int unsigned k = 0; k < list_len; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0)      v = $urandom();
            else if (r == 1) v = (k[0]) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else             v = pool[$urandom_range(0, 7)];
            send_item(v, k == list_len - 1);
         end
         sent += list_len;
         list_no++;
      end
   endtask

   // enough lists to wrap the block's list tag; stale entries must never match
   task automatic test_list_tag_wrap(input int unsigned list_total);
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      a = $urandom();
      b = a ^ 32'h0000_0001;
      idle_enable = 1'b0;
      for (int unsigned n = 0; n < list_total; n++) begin
         if (n % 40 == 0) idle_enable = ~idle_enable;
         case ($urandom_range(0, 3))
            0: send_item(a, 1'b1);
            1: begin
               send_item(a, 1'b0);
               send_item(a, 1'b1);
            end
            2: begin
               send_item(b, 1'b0);
               send_item(a, 1'b1);
            end
            default: send_item(b, 1'b1);
         endcase
      end
   endtask

   task automatic test_backpressure();
      logic signed [DATA_W-1:0] v;
      idle_enable  = 1'b0;
      rsp_hold_len = RSP_HOLD_LEN;
      for (int k = 0; k < 40; k++) begin
         v = (k % 3 == 0) ? $signed(32'(k)) : $signed($urandom());
         send_item(v, k == 39);
      end
   endtask

   initial begin
      fail_count  = 0;
      seen_fill   = 0;
      idle_enable = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_store_full();
      test_random_lists(950);
      test_list_tag_wrap(300);
      test_backpressure();
      idle_enable = 1'b1;
      test_random_lists(40);
      stop_sending();

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("stream_duplicate_filter_tb passed");
      end else begin
         $display("stream_duplicate_filter_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/sdf_pkg.sv
rtl/core/sdf_stream_if.sv
rtl/core/sdf_ram.sv
rtl/core/sdf_ctrl.sv
rtl/core/sdf_dpath.sv
rtl/core/stream_duplicate_filter.sv
rtl/core/sdf_chk.sv
verif/stream_duplicate_filter_tb.sv
